// ===== hdl/lcg_rng_pkg.sv =====
package lcg_rng_pkg;

	// Data path width and the width of a bit counter over it.
	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DATA_W);

	// Generator constants: x <- x * LCG_MUL + LCG_INC (mod 2^32).
	localparam logic [DATA_W-1:0] LCG_MUL = 32'd1103515245;
	localparam logic [DATA_W-1:0] LCG_INC = 32'd12345;

	// Bit fields taken from each new generator state.
	localparam int FIRST_HI = 26;
	localparam int NEXT_HI  = 25;
	localparam int FIELD_LO = 16;
	localparam int NEXT_W   = NEXT_HI - FIELD_LO + 1;

	// Command codes.
	localparam logic [1:0] CMD_SEED  = 2'd0;
	localparam logic [1:0] CMD_WORD  = 2'd1;
	localparam logic [1:0] CMD_RANGE = 2'd2;

	// Status codes.
	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_TIMEOUT  = 2'd1;
	localparam logic [1:0] STS_ZERO_DIV = 2'd2;

	// Number of generator steps per random word.
	localparam int LCG_STEPS = 3;
	localparam int STEP_W    = $clog2(LCG_STEPS);

endpackage

// ===== hdl/lcg_rng_if.sv =====
// Request channel: one command transaction.
interface lcg_rng_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] seed_value;
	logic signed [31:0] range_low;
	logic signed [31:0] range_high;
	logic        hw_ready;
	logic [31:0] hw_word;

	modport source (
		output valid, command, seed_value, range_low, range_high, hw_ready, hw_word,
		input  ready
	);
	modport sink (
		input  valid, command, seed_value, range_low, range_high, hw_ready, hw_word,
		output ready
	);
endinterface

// Response channel: one result transaction.
interface lcg_rng_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_value;
	logic        from_hardware;
	logic [1:0]  status;

	modport source (
		output valid, random_value, from_hardware, status,
		input  ready
	);
	modport sink (
		input  valid, random_value, from_hardware, status,
		output ready
	);
endinterface

// ===== hdl/lcg_rng_mul.sv =====
// Bit-serial multiply-add: result = op * LCG_MUL + LCG_INC (mod 2^32).
// One multiplier bit is consumed per cycle.
module lcg_rng_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [lcg_rng_pkg::DATA_W-1:0] op,
	output logic                           done,
	output logic [lcg_rng_pkg::DATA_W-1:0] result
);

	logic                           busy_q;
	logic                           done_q;
	logic [lcg_rng_pkg::CNT_W-1:0]  cnt_q;
	logic [lcg_rng_pkg::DATA_W-1:0] mplier_q;
	logic [lcg_rng_pkg::DATA_W-1:0] mcand_q;
	logic [lcg_rng_pkg::DATA_W-1:0] acc_q;

	// Control: busy for one pass over the multiplier bits, then a done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lcg_rng_pkg::CNT_W'(lcg_rng_pkg::DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Data path: add the shifted multiplicand when the current bit is set.
	always_ff @(posedge clk) begin
		if (start) begin
			mplier_q <= op;
			mcand_q  <= lcg_rng_pkg::LCG_MUL;
			acc_q    <= lcg_rng_pkg::LCG_INC;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[lcg_rng_pkg::DATA_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[lcg_rng_pkg::DATA_W-1:1]};
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

// ===== hdl/lcg_rng_div.sv =====
// Restoring divider that yields the remainder, one quotient bit per cycle.
module lcg_rng_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [lcg_rng_pkg::DATA_W-1:0] dividend,
	input  logic [lcg_rng_pkg::DATA_W-1:0] divisor,
	output logic                           done,
	output logic [lcg_rng_pkg::DATA_W-1:0] remainder
);

	logic                           busy_q;
	logic                           done_q;
	logic [lcg_rng_pkg::CNT_W-1:0]  cnt_q;
	logic [lcg_rng_pkg::DATA_W-1:0] dvd_q;
	logic [lcg_rng_pkg::DATA_W-1:0] dsr_q;
	logic [lcg_rng_pkg::DATA_W-1:0] rem_q;
	logic [lcg_rng_pkg::DATA_W:0]   trial;
	logic [lcg_rng_pkg::DATA_W:0]   diff;

	// Shift in the next dividend bit and try to subtract the divisor.
	assign trial = {rem_q, dvd_q[lcg_rng_pkg::DATA_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	// Control: one pass over the dividend bits, then a done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lcg_rng_pkg::CNT_W'(lcg_rng_pkg::DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Data path: keep the difference when it did not go negative.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[lcg_rng_pkg::DATA_W-2:0], 1'b0};
			if (!diff[lcg_rng_pkg::DATA_W]) begin
				rem_q <= diff[lcg_rng_pkg::DATA_W-1:0];
			end else begin
				rem_q <= trial[lcg_rng_pkg::DATA_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== hdl/lcg_random_range_generator.sv =====
// Seed, unknown command or hardware word: the request goes from idle to the finish state, then to the result register.
// Generated word: three generator steps on the bit-serial multiply-add, then the finish state and the result register.
// Range: the reduce state, then the divider unless the divisor is zero, before the finish state.
// One transaction is in work at a time; a new one is taken once the result is registered.
// Reset clears the generator state to zero and empties the result register.
module lcg_random_range_generator (
	input  logic               clk,
	input  logic               arst_n,
	lcg_rng_req_if.sink        req,
	lcg_rng_rsp_if.source      rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LCG,
		ST_RED,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                              state_q;
	logic [lcg_rng_pkg::DATA_W-1:0]      gen_q;
	logic [1:0]                          cmd_q;
	logic [lcg_rng_pkg::DATA_W-1:0]      low_q;
	logic [lcg_rng_pkg::DATA_W-1:0]      high_q;
	logic [lcg_rng_pkg::DATA_W-1:0]      r_q;
	logic [lcg_rng_pkg::DATA_W-1:0]      value_q;
	logic                                from_hw_q;
	logic [1:0]                          status_q;
	logic [lcg_rng_pkg::STEP_W-1:0]      step_q;
	logic                                out_valid_q;
	logic [lcg_rng_pkg::DATA_W-1:0]      out_value_q;
	logic                                out_from_hw_q;
	logic [1:0]                          out_status_q;

	logic                                accept;
	logic                                is_gen_cmd;
	logic                                last_step;
	logic                                mul_start;
	logic [lcg_rng_pkg::DATA_W-1:0]      mul_op;
	logic                                mul_done;
	logic [lcg_rng_pkg::DATA_W-1:0]      mul_res;
	logic                                div_start;
	logic                                div_done;
	logic [lcg_rng_pkg::DATA_W-1:0]      div_rem;
	logic [lcg_rng_pkg::DATA_W-1:0]      divisor;
	logic                                out_free;

	// Handshake and command decode.
	assign req.ready  = (state_q == ST_IDLE);
	assign accept     = req.valid && req.ready;
	assign is_gen_cmd = (req.command == lcg_rng_pkg::CMD_WORD) ||
	                    (req.command == lcg_rng_pkg::CMD_RANGE);
	assign last_step  = (step_q == lcg_rng_pkg::STEP_W'(lcg_rng_pkg::LCG_STEPS - 1));
	assign divisor    = high_q - low_q + 1'b1;
	assign out_free   = !out_valid_q || rsp.ready;

	// The first generator step starts from the stored state, later ones chain on.
	assign mul_start = (accept && is_gen_cmd && !req.hw_ready) ||
	                   (state_q == ST_LCG && mul_done && !last_step);
	assign mul_op    = (state_q == ST_LCG) ? mul_res : gen_q;
	assign div_start = (state_q == ST_RED) && (divisor != '0);

	lcg_rng_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op     (mul_op),
		.done   (mul_done),
		.result (mul_res)
	);

	lcg_rng_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (r_q),
		.divisor   (divisor),
		.done      (div_done),
		.remainder (div_rem)
	);

	// Sequencer: state, generator state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			gen_q         <= '0;
			step_q        <= '0;
			out_valid_q   <= 1'b0;
			cmd_q         <= lcg_rng_pkg::CMD_SEED;
			low_q         <= '0;
			high_q        <= '0;
			r_q           <= '0;
			value_q       <= '0;
			from_hw_q     <= 1'b0;
			status_q      <= lcg_rng_pkg::STS_OK;
			out_value_q   <= '0;
			out_from_hw_q <= 1'b0;
			out_status_q  <= lcg_rng_pkg::STS_OK;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q     <= req.command;
						low_q     <= req.range_low;
						high_q    <= req.range_high;
						value_q   <= '0;
						from_hw_q <= 1'b0;
						status_q  <= lcg_rng_pkg::STS_OK;
						step_q    <= '0;
						if (req.command == lcg_rng_pkg::CMD_SEED) begin
							if (gen_q == '0 && !req.hw_ready) begin
								status_q <= lcg_rng_pkg::STS_TIMEOUT;
							end
							gen_q   <= gen_q + req.seed_value;
							state_q <= ST_FIN;
						end else if (is_gen_cmd) begin
							if (req.hw_ready) begin
								r_q       <= req.hw_word;
								value_q   <= req.hw_word;
								from_hw_q <= 1'b1;
								state_q   <= (req.command == lcg_rng_pkg::CMD_RANGE) ?
								             ST_RED : ST_FIN;
							end else begin
								state_q <= ST_LCG;
							end
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_LCG: begin
					// Collect the field of each new state into the word.
					if (mul_done) begin
						gen_q  <= mul_res;
						step_q <= step_q + 1'b1;
						if (step_q == '0) begin
							r_q <= lcg_rng_pkg::DATA_W'(
							       mul_res[lcg_rng_pkg::FIRST_HI:lcg_rng_pkg::FIELD_LO]);
						end else begin
							r_q <= {r_q[lcg_rng_pkg::DATA_W-lcg_rng_pkg::NEXT_W-1:0],
							        mul_res[lcg_rng_pkg::NEXT_HI:lcg_rng_pkg::FIELD_LO]};
						end
						if (last_step) begin
							value_q <= {r_q[lcg_rng_pkg::DATA_W-lcg_rng_pkg::NEXT_W-1:0],
							            mul_res[lcg_rng_pkg::NEXT_HI:lcg_rng_pkg::FIELD_LO]};
							state_q <= (cmd_q == lcg_rng_pkg::CMD_RANGE) ? ST_RED : ST_FIN;
						end
					end
				end
				ST_RED: begin
					// A full 32-bit range wraps the divisor to zero.
					if (divisor == '0) begin
						value_q  <= r_q;
						status_q <= lcg_rng_pkg::STS_ZERO_DIV;
						state_q  <= ST_FIN;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						value_q <= low_q + div_rem;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// Hand the result to the output register once it is free.
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_value_q   <= value_q;
						out_from_hw_q <= from_hw_q;
						out_status_q  <= status_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.random_value  = out_value_q;
	assign rsp.from_hardware = out_from_hw_q;
	assign rsp.status        = out_status_q;

endmodule

// ===== sim/lcg_random_range_generator_tb.sv =====
`timescale 1ns / 1ps

module lcg_random_range_generator_tb;

	// Command code that the block treats as unknown.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct packed {
		logic [1:0]         command;
		logic [31:0]        seed_value;
		logic signed [31:0] range_low;
		logic signed [31:0] range_high;
		logic               hw_ready;
		logic [31:0]        hw_word;
	} request_t;

	typedef struct packed {
		logic [31:0] random_value;
		logic        from_hardware;
		logic [1:0]  status;
	} result_t;

	// Tracks the generator state and the queue of results still owed by the block.
	class lcg_range_scoreboard;
		logic [31:0] gen_state;
		result_t     pending[$];
		int          mismatches;
		int          results_seen;
		int          seeds, words, ranges, unknowns;
		int          timeouts, zero_divs, hw_values;

		function new();
			gen_state = '0;
			mismatches = 0;
			results_seen = 0;
			seeds = 0;
			words = 0;
			ranges = 0;
			unknowns = 0;
			timeouts = 0;
			zero_divs = 0;
			hw_values = 0;
		endfunction

		// One step of the congruential generator; returns the new state.
		function logic [31:0] step_state();
			gen_state = gen_state * lcg_rng_pkg::LCG_MUL + lcg_rng_pkg::LCG_INC;
			return gen_state;
		endfunction

		// Three generator steps joined into a 31-bit word.
		function logic [31:0] generated_word();
			logic [31:0] s1, s2, s3;
			s1 = step_state();
			s2 = step_state();
			s3 = step_state();
			return {1'b0, s1[lcg_rng_pkg::FIRST_HI:lcg_rng_pkg::FIELD_LO],
				s2[lcg_rng_pkg::NEXT_HI:lcg_rng_pkg::FIELD_LO],
				s3[lcg_rng_pkg::NEXT_HI:lcg_rng_pkg::FIELD_LO]};
		endfunction

		// Called for every accepted request transaction.
		function void note_request(request_t r);
			result_t     exp;
			logic [31:0] word;
			logic [31:0] span;
			exp = '0;
			case (r.command) inside
				lcg_rng_pkg::CMD_SEED: begin
					seeds++;
					if (gen_state == '0 && !r.hw_ready) begin
						exp.status = lcg_rng_pkg::STS_TIMEOUT;
						timeouts++;
					end
					gen_state = gen_state + r.seed_value;
				end
				lcg_rng_pkg::CMD_WORD, lcg_rng_pkg::CMD_RANGE: begin
					if (r.hw_ready) begin
						word = r.hw_word;
						exp.from_hardware = 1'b1;
						hw_values++;
					end else begin
						word = generated_word();
					end
					if (r.command == lcg_rng_pkg::CMD_WORD) begin
						words++;
						exp.random_value = word;
					end else begin
						ranges++;
						span = $unsigned(r.range_high) - $unsigned(r.range_low) + 32'd1;
						if (span == '0) begin
							exp.random_value = word;
							exp.status = lcg_rng_pkg::STS_ZERO_DIV;
							zero_divs++;
						end else begin
							exp.random_value = $unsigned(r.range_low) + (word % span);
						end
					end
				end
				default: begin
					unknowns++;
				end
			endcase
			pending.push_back(exp);
		endfunction

		task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
			$display("MISMATCH result %0d %s: got %h, expected %h",
				results_seen, field, got, want);
			mismatches++;
		endtask

		// Called for every accepted result transaction.
		task check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", got.random_value, '0);
			end else begin
				want = pending.pop_front();
				if (got.random_value !== want.random_value)
					report_mismatch("random_value", got.random_value, want.random_value);
				if (got.from_hardware !== want.from_hardware)
					report_mismatch("from_hardware", 32'(got.from_hardware),
						32'(want.from_hardware));
				if (got.status !== want.status)
					report_mismatch("status", 32'(got.status), 32'(want.status));
			end
			results_seen++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   send_gap_max = 4;
	int   recv_gap_max = 4;
	int   hold_cycles = 0;
	int   holds_done = 0;
	int   cycle_count = 0;
	lcg_range_scoreboard sb = new();

	lcg_rng_req_if req_ch ();
	lcg_rng_rsp_if rsp_ch ();

	lcg_random_range_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #1 clk = ~clk;

	function automatic request_t make_request(logic [1:0] cmd, logic [31:0] seed,
			logic [31:0] low, logic [31:0] high, logic rdy, logic [31:0] hw);
		request_t r;
		r.command = cmd;
		r.seed_value = seed;
		r.range_low = low;
		r.range_high = high;
		r.hw_ready = rdy;
		r.hw_word = hw;
		return r;
	endfunction

	// Random request; ranges are mostly narrow, with full, equal and inverted spans mixed in.
	function automatic request_t random_request();
		request_t r;
		int       pick;
		r = make_request(lcg_rng_pkg::CMD_SEED, $urandom, $urandom, $urandom,
			$urandom_range(0, 99) < 25, $urandom);
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			r.command = lcg_rng_pkg::CMD_SEED;
			pick = $urandom_range(0, 9);
			if (pick == 0)
				r.seed_value = '0;
			else if (pick == 1)
				r.seed_value = -sb.gen_state;
		end else if (pick < 50) begin
			r.command = lcg_rng_pkg::CMD_WORD;
		end else if (pick < 95) begin
			r.command = lcg_rng_pkg::CMD_RANGE;
			pick = $urandom_range(0, 9);
			case (pick)
				0, 1, 2, 3, 4: r.range_high = r.range_low + $urandom_range(0, 255);
				5: r.range_high = r.range_low - 1;
				6: r.range_high = r.range_low;
				7: ;
				8: begin
					r.range_low = 32'h8000_0000;
					r.range_high = 32'h7FFF_FFFF - $urandom_range(0, 3);
				end
				default: r.range_high = r.range_low - $urandom_range(2, 1000);
			endcase
		end else begin
			r.command = CMD_UNUSED;
		end
		return r;
	endfunction

	// Offers one request after a random gap and returns once it is accepted.
	task automatic send_request(request_t r);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= r.command;
		req_ch.seed_value <= r.seed_value;
		req_ch.range_low <= r.range_low;
		req_ch.range_high <= r.range_high;
		req_ch.hw_ready <= r.hw_ready;
		req_ch.hw_word <= r.hw_word;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.note_request(r);
	endtask

	task automatic send_random(int count);
		repeat (count) send_request(random_request());
	endtask

	// Result side: random stalls, plus a long hold-off whenever one is requested.
	initial begin : result_sink
		int stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, recv_gap_max);
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
				holds_done++;
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			sb.check_result({rsp_ch.random_value, rsp_ch.from_hardware, rsp_ch.status});
		end
	end

	// Watchdog on the whole run.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding",
			cycle_count, sb.pending.size());
		$display("TEST FAILED");
		$finish;
	end

	// Reset, directed requests, then random phases.
	initial begin : stimulus
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.command <= lcg_rng_pkg::CMD_SEED;
		req_ch.seed_value <= '0;
		req_ch.range_low <= '0;
		req_ch.range_high <= '0;
		req_ch.hw_ready <= 1'b0;
		req_ch.hw_word <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Seeding from a zero state without hardware reports a timeout.
		send_request(make_request(lcg_rng_pkg::CMD_SEED, 32'd0, 0, 0, 1'b0, 32'd0));
		send_request(make_request(lcg_rng_pkg::CMD_SEED, 32'd0, 0, 0, 1'b1, 32'hFFFF_FFFF));
		send_request(make_request(lcg_rng_pkg::CMD_WORD, 32'd0, 0, 0, 1'b0, 32'hFFFF_FFFF));
		send_request(make_request(lcg_rng_pkg::CMD_SEED, 32'hFFFF_FFFF, 0, 0, 1'b0, 32'd0));
		send_request(make_request(lcg_rng_pkg::CMD_WORD, 32'd0, 0, 0, 1'b1, 32'hFFFF_FFFF));
		send_request(make_request(lcg_rng_pkg::CMD_WORD, 32'hFFFF_FFFF, 0, 0, 1'b1, 32'd0));
		send_request(make_request(lcg_rng_pkg::CMD_RANGE, 32'd0, 32'd10, 32'd20,
			1'b1, 32'd12345));
		send_request(make_request(lcg_rng_pkg::CMD_RANGE, 32'd0, -32'sd5, 32'sd5,
			1'b0, 32'd0));
		// Full 32-bit span: the divisor wraps to zero.
		send_request(make_request(lcg_rng_pkg::CMD_RANGE, 32'd0, 32'h8000_0000,
			32'h7FFF_FFFF, 1'b0, 32'd0));
		send_request(make_request(lcg_rng_pkg::CMD_RANGE, 32'd0, 32'h8000_0000,
			32'h7FFF_FFFF, 1'b1, 32'hDEAD_BEEF));
		send_request(make_request(lcg_rng_pkg::CMD_RANGE, 32'd0, 32'h0, 32'hFFFF_FFFF,
			1'b0, 32'd0));
		send_request(make_request(lcg_rng_pkg::CMD_RANGE, 32'd0, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 1'b0, 32'd0));
		// Inverted bounds are reduced by the wrapped divisor.
		send_request(make_request(lcg_rng_pkg::CMD_RANGE, 32'd0, 32'h7FFF_FFFF,
			32'h8000_0000, 1'b1, 32'hFFFF_FFFF));
		send_request(make_request(lcg_rng_pkg::CMD_RANGE, 32'd0, 32'd100, 32'd50,
			1'b0, 32'd0));
		// Unknown command leaves the state alone.
		send_request(make_request(CMD_UNUSED, $urandom, $urandom, $urandom, 1'b0, $urandom));
		send_request(make_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b1, 32'hFFFF_FFFF));
		// Bring the state back to zero with hardware ready, then seed again without hardware.
		send_request(make_request(lcg_rng_pkg::CMD_SEED, -sb.gen_state, 0, 0, 1'b1, 32'd0));
		send_request(make_request(lcg_rng_pkg::CMD_SEED, 32'd5, 0, 0, 1'b0, 32'd0));
		send_request(make_request(lcg_rng_pkg::CMD_WORD, 32'd0, 0, 0, 1'b0, 32'd0));
		send_request(make_request(lcg_rng_pkg::CMD_SEED, 32'h8000_0000, 0, 0, 1'b0, 32'd0));
		send_request(make_request(lcg_rng_pkg::CMD_RANGE, 32'd0, 32'h8000_0000,
			32'h8000_0001, 1'b0, 32'd0));

		// Random traffic with idling on both sides.
		send_random(400);

		// A stretch with no idling at all.
		send_gap_max = 0;
		recv_gap_max = 0;
		send_random(300);

		// Receiver holds off for a long time while requests keep coming.
		send_gap_max = 4;
		recv_gap_max = 4;
		hold_cycles = HOLD_OFF_CYCLES;
		send_gap_max = 0;
		send_random(20);
		send_gap_max = 4;
		send_random(380);
		req_ch.valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d seeds (%0d timeouts), %0d words, %0d ranges",
			sb.results_seen, sb.seeds, sb.timeouts, sb.words, sb.ranges);
		$display("Zero divisors %0d, unknown commands %0d, hardware words %0d, hold-offs %0d",
			sb.zero_divs, sb.unknowns, sb.hw_values, holds_done);
		if (sb.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
